// ===== hw/rtl/stepper_position_velocity_stepper_core_defines.svh =====
// Assertion macros shared by the stepper core modules.
`ifndef STEPPER_POSITION_VELOCITY_STEPPER_CORE_DEFINES_SVH
`define STEPPER_POSITION_VELOCITY_STEPPER_CORE_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define SPV_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("spv assertion failed");

// Next-cycle implication, checked out of reset.
`define SPV_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("spv assertion failed");

`endif

// ===== hw/rtl/spv_pkg.sv =====
// Types and constants of the stepper position/velocity core.
package spv_pkg;

    localparam int SPR_W      = 20;
    localparam int PERIOD_W   = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;

    localparam logic [CFG_IDX_W-1:0] CFG_REV_STEPS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_PERIOD = 2'd1;

    localparam logic MD_POS = 1'b0;
    localparam logic MD_VEL = 1'b1;

    localparam logic [15:0] SPR_RESET    = 16'd6400;
    localparam logic [15:0] PERIOD_RESET = 16'd25;

    // round(2^48 / (2*pi)), split for the 26x23 partial products
    localparam logic [45:0] INV_TWO_PI_Q48 = 46'd44798133900177;
    localparam int          K_LO_W         = 23;
    localparam int          P_LO_W         = 26;
    localparam int          PROD_W         = 52;
    localparam int          PP_W           = 49;
    localparam int          ACC_W          = 98;
    localparam logic [4:0]  PP_LAST        = 5'd4;

    localparam int          FRAC_SHIFT = 15;
    localparam int          DIV_BITS   = PERIOD_W + FRAC_SHIFT;
    localparam logic [4:0]  DIV_LAST   = 5'(DIV_BITS - 1);

    localparam logic signed [31:0] POS_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] POS_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic        mode;
        logic        neg;
        logic [31:0] mag;
    } t_cmd;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_MUL,
        BK_PP,
        BK_DIV,
        BK_FIN
    } t_back_state;

endpackage

// ===== hw/rtl/spv_front.sv =====
// Front end: accepts tick beats, tracks the active command, queues its mode, sign and magnitude.
module spv_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic                 i_new_command,
    input  logic                 i_mode,
    input  logic signed [31:0]   i_setpoint,
    input  logic                 i_full,
    output logic                 o_push,
    output spv_pkg::t_cmd        o_cmd
);
    import spv_pkg::*;

    logic        r_mode;
    logic [31:0] r_setpoint;
    logic        n_mode;
    logic [31:0] n_setpoint;

    always_comb begin
        o_ready    = !i_full;
        o_push     = i_valid && !i_full;
        n_mode     = r_mode;
        n_setpoint = r_setpoint;
        if (i_new_command) begin
            n_mode     = i_mode;
            n_setpoint = i_setpoint;
        end
        o_cmd.mode = n_mode;
        o_cmd.neg  = n_setpoint[31];
        o_cmd.mag  = n_setpoint[31] ? (~n_setpoint + 32'd1) : n_setpoint;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= MD_POS;
            r_setpoint <= '0;
        end else if (o_push) begin
            r_mode     <= n_mode;
            r_setpoint <= n_setpoint;
        end
    end

endmodule

// ===== hw/rtl/spv_fifo.sv =====
// Command queue between front and back ends.
module spv_fifo #(
    parameter int DEPTH = 2
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  spv_pkg::t_cmd  i_wdata,
    output logic           o_full,
    input  logic           i_pop,
    output spv_pkg::t_cmd  o_rdata,
    output logic           o_empty
);
    import spv_pkg::*;
`include "stepper_position_velocity_stepper_core_defines.svh"

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == CNT_FULL);
    assign o_empty = (r_count == '0);
    assign o_rdata = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    `SPV_ASSERT_IMPL(a_no_push_full, i_push, r_count != CNT_FULL)
    `SPV_ASSERT_IMPL(a_no_pop_empty, i_pop, r_count != '0)
    `SPV_ASSERT_NEXT(a_push_fills, i_push && !i_pop, r_count != '0)

endmodule

// ===== hw/rtl/spv_back.sv =====
// Back end: target, half period and step update, with multiplier and serial divider.
module spv_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_empty,
    input  spv_pkg::t_cmd         i_cmd,
    output logic                  o_pop,
    input  logic [19:0]           i_rev_steps,
    input  logic [15:0]           i_base_period,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic                  o_step_pulse,
    output logic                  o_direction,
    output logic [31:0]           o_half_period_us,
    output logic signed [31:0]    o_position_count
);
    import spv_pkg::*;
`include "stepper_position_velocity_stepper_core_defines.svh"

    t_back_state          r_state, n_state;
    logic                 r_mode, n_mode;
    logic                 r_neg, n_neg;
    logic [31:0]          r_mag, n_mag;
    logic [PROD_W-1:0]    r_p, n_p;
    logic [PP_W-1:0]      r_pp, n_pp;
    logic [1:0]           r_pp_sh, n_pp_sh;
    logic [ACC_W-1:0]     r_acc, n_acc;
    logic [4:0]           r_cnt, n_cnt;
    logic [31:0]          r_rem, n_rem;
    logic [DIV_BITS-1:0]  r_q, n_q;
    logic signed [31:0]   r_step_count, n_step_count;
    logic signed [31:0]   r_target, n_target;
    logic [31:0]          r_half, n_half;
    logic                 r_dir, n_dir;
    logic                 r_out_valid, n_out_valid;
    logic                 r_out_pulse, n_out_pulse;
    logic                 r_out_dir, n_out_dir;
    logic [31:0]          r_out_half, n_out_half;
    logic signed [31:0]   r_out_pos, n_out_pos;

    logic [P_LO_W-1:0]    w_mul_a;
    logic [K_LO_W-1:0]    w_mul_b;
    logic [PP_W-1:0]      w_pp;
    logic [ACC_W-1:0]     w_pp_wide;
    logic [ACC_W-1:0]     w_add;
    logic [32:0]          w_trial;
    logic [33:0]          w_t;
    logic                 w_load;

    assign o_valid          = r_out_valid;
    assign o_step_pulse     = r_out_pulse;
    assign o_direction      = r_out_dir;
    assign o_half_period_us = r_out_half;
    assign o_position_count = r_out_pos;

    always_comb begin
        w_mul_a   = r_cnt[1] ? r_p[PROD_W-1:P_LO_W] : r_p[P_LO_W-1:0];
        w_mul_b   = r_cnt[0] ? INV_TWO_PI_Q48[45:K_LO_W] : INV_TWO_PI_Q48[K_LO_W-1:0];
        w_pp      = PP_W'(w_mul_a) * PP_W'(w_mul_b);
        w_pp_wide = {{(ACC_W-PP_W){1'b0}}, r_pp};
        case (r_pp_sh)
            2'd0:    w_add = w_pp_wide;
            2'd1:    w_add = w_pp_wide << K_LO_W;
            2'd2:    w_add = w_pp_wide << P_LO_W;
            default: w_add = w_pp_wide << (P_LO_W + K_LO_W);
        endcase
        w_trial = {r_rem, r_q[DIV_BITS-1]};
        w_t     = r_acc[ACC_W-1:64];
    end

    always_comb begin
        n_state      = r_state;
        n_mode       = r_mode;
        n_neg        = r_neg;
        n_mag        = r_mag;
        n_p          = r_p;
        n_pp         = r_pp;
        n_pp_sh      = r_pp_sh;
        n_acc        = r_acc;
        n_cnt        = r_cnt;
        n_rem        = r_rem;
        n_q          = r_q;
        n_step_count = r_step_count;
        n_target     = r_target;
        n_half       = r_half;
        n_dir        = r_dir;
        n_out_valid  = r_out_valid && !i_ready;
        n_out_pulse  = r_out_pulse;
        n_out_dir    = r_out_dir;
        n_out_half   = r_out_half;
        n_out_pos    = r_out_pos;
        o_pop        = 1'b0;
        w_load       = 1'b0;

        unique case (r_state)
            BK_IDLE: begin
                if (!i_empty) begin
                    o_pop  = 1'b1;
                    n_mode = i_cmd.mode;
                    n_neg  = i_cmd.neg;
                    n_mag  = i_cmd.mag;
                    n_cnt  = '0;
                    n_rem  = '0;
                    n_q    = {i_base_period, {FRAC_SHIFT{1'b0}}};
                    if (i_cmd.mode == MD_POS) begin
                        n_state = BK_MUL;
                    end else if (i_cmd.mag != '0) begin
                        n_state = BK_DIV;
                    end else begin
                        n_state = BK_FIN;
                    end
                end
            end
            BK_MUL: begin
                n_p     = PROD_W'(r_mag) * PROD_W'(i_rev_steps);
                n_acc   = '0;
                n_cnt   = '0;
                n_state = BK_PP;
            end
            BK_PP: begin
                if (r_cnt != PP_LAST) begin
                    n_pp    = w_pp;
                    n_pp_sh = r_cnt[1:0];
                end
                if (r_cnt != '0) begin
                    n_acc = r_acc + w_add;
                end
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == PP_LAST) begin
                    n_state = BK_FIN;
                end
            end
            BK_DIV: begin
                if (w_trial >= {1'b0, r_mag}) begin
                    n_rem = 32'(w_trial - {1'b0, r_mag});
                    n_q   = {r_q[DIV_BITS-2:0], 1'b1};
                end else begin
                    n_rem = w_trial[31:0];
                    n_q   = {r_q[DIV_BITS-2:0], 1'b0};
                end
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == DIV_LAST) begin
                    n_state = BK_FIN;
                end
            end
            BK_FIN: begin
                if (!r_out_valid || i_ready) begin
                    w_load = 1'b1;
                    if (r_mode == MD_POS) begin
                        if (r_neg) begin
                            n_target = (w_t >= 34'h0_8000_0000) ? POS_MIN
                                     : $signed(~w_t[31:0] + 32'd1);
                        end else begin
                            n_target = (w_t > 34'h0_7FFF_FFFF) ? POS_MAX
                                     : $signed(w_t[31:0]);
                        end
                        n_half = {17'd0, i_base_period[15:1]};
                    end else if (r_mag != '0) begin
                        if (r_neg) begin
                            if (r_target != POS_MIN) begin
                                n_target = r_target - 32'sd1;
                            end
                        end else begin
                            if (r_target != POS_MAX) begin
                                n_target = r_target + 32'sd1;
                            end
                        end
                        n_half = {{(32-DIV_BITS){1'b0}}, r_q};
                    end
                    n_out_pulse = 1'b0;
                    if (n_target > r_step_count) begin
                        n_dir        = 1'b1;
                        n_out_pulse  = 1'b1;
                        n_step_count = r_step_count + 32'sd1;
                    end else if (n_target < r_step_count) begin
                        n_dir        = 1'b0;
                        n_out_pulse  = 1'b1;
                        n_step_count = r_step_count - 32'sd1;
                    end
                    n_out_valid = 1'b1;
                    n_out_dir   = n_dir;
                    n_out_half  = n_half;
                    n_out_pos   = n_step_count;
                    n_state     = BK_IDLE;
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= BK_IDLE;
            r_step_count <= '0;
            r_target     <= '0;
            r_half       <= '0;
            r_dir        <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_step_count <= n_step_count;
            r_target     <= n_target;
            r_half       <= n_half;
            r_dir        <= n_dir;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode      <= n_mode;
        r_neg       <= n_neg;
        r_mag       <= n_mag;
        r_p         <= n_p;
        r_pp        <= n_pp;
        r_pp_sh     <= n_pp_sh;
        r_acc       <= n_acc;
        r_cnt       <= n_cnt;
        r_rem       <= n_rem;
        r_q         <= n_q;
        r_out_pulse <= n_out_pulse;
        r_out_dir   <= n_out_dir;
        r_out_half  <= n_out_half;
        r_out_pos   <= n_out_pos;
    end

    `SPV_ASSERT_IMPL(a_div_velocity, r_state == BK_DIV, (r_mode == MD_VEL) && (r_mag != '0))
    `SPV_ASSERT_NEXT(a_no_pulse_hold, w_load && !n_out_pulse,
        r_step_count == $past(r_step_count))
    `SPV_ASSERT_IMPL(a_pop_idle, o_pop, (r_state == BK_IDLE) && !i_empty)

endmodule

// ===== hw/rtl/stepper_position_velocity_stepper_core.sv =====
// Top level of the stepper position/velocity core: config registers and front/queue/back.
// The back end takes one command at a time: position commands run the multiply-accumulate
// sequence, velocity commands the 31-step serial divider, zero velocity neither; the queue
// holds further commands meanwhile, and the result beat waits for the output ready.
// Reset is synchronous, active low: counters, command, target, half period and direction
// clear, the revolution step count returns to 6400 and the base period to 25.
module stepper_position_velocity_stepper_core #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [spv_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [spv_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic                            i_new_command,
    input  logic                            i_mode,
    input  logic signed [31:0]              i_setpoint,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic                            o_step_pulse,
    output logic                            o_direction,
    output logic [31:0]                     o_half_period_us,
    output logic signed [31:0]              o_position_count
);
    import spv_pkg::*;

    logic [SPR_W-1:0]    r_rev_steps;
    logic [PERIOD_W-1:0] r_base_period;
    logic                w_push;
    logic                w_pop;
    logic                w_full;
    logic                w_empty;
    t_cmd                w_wcmd;
    t_cmd                w_rcmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rev_steps   <= SPR_W'(SPR_RESET);
            r_base_period <= PERIOD_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_REV_STEPS:   r_rev_steps   <= i_cfg_data[SPR_W-1:0];
                CFG_BASE_PERIOD: r_base_period <= i_cfg_data[PERIOD_W-1:0];
                default: ;
            endcase
        end
    end

    spv_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_in_valid),
        .o_ready       (o_in_ready),
        .i_new_command (i_new_command),
        .i_mode        (i_mode),
        .i_setpoint    (i_setpoint),
        .i_full        (w_full),
        .o_push        (w_push),
        .o_cmd         (w_wcmd)
    );

    spv_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_wdata (w_wcmd),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_rdata (w_rcmd),
        .o_empty (w_empty)
    );

    spv_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_empty          (w_empty),
        .i_cmd            (w_rcmd),
        .o_pop            (w_pop),
        .i_rev_steps      (r_rev_steps),
        .i_base_period    (r_base_period),
        .o_valid          (o_out_valid),
        .i_ready          (i_out_ready),
        .o_step_pulse     (o_step_pulse),
        .o_direction      (o_direction),
        .o_half_period_us (o_half_period_us),
        .o_position_count (o_position_count)
    );

endmodule
